// File: rtl/core/hyperloglog_register_update_top_assert.svh
// Assertion macros for the HyperLogLog register engine.
// Each check is clocked on clk and held off while arst_n is low.
`ifndef HYPERLOGLOG_REGISTER_UPDATE_TOP_ASSERT_SVH
`define HYPERLOGLOG_REGISTER_UPDATE_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define HLL_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");
`define HLL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");
`else
`define HLL_ASSERT_IMPL(lbl, ante, cons)
`define HLL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/core/hllru_pkg.sv
package hllru_pkg;

	localparam int PRECISION = 12;
	localparam int IDX_W = PRECISION;
	localparam int REG_CNT = 1 << PRECISION;
	localparam int CNT_W = PRECISION + 1;
	localparam int FRAC_BITS = 63 - PRECISION;
	// Width of the hash bits above the index, sentinel bit included.
	localparam int RHO_W = 65 - PRECISION;
	localparam int GRP_N = (RHO_W + 7) / 8;
	localparam int PAD_W = GRP_N * 8;

	localparam int MIX_SHIFT = 33;
	localparam logic [63:0] MIX_MUL_A = 64'hFF51AFD7ED558CCD;
	localparam logic [63:0] MIX_MUL_B = 64'hC4CEB9FE1A85EC53;
	localparam logic [63:0] HARM_INIT = 64'(REG_CNT) << FRAC_BITS;

	// Steps of one 64 by 64 bit multiply on the shared 32 by 32 bit unit.
	localparam logic [1:0] MS_LL  = 2'd0;
	localparam logic [1:0] MS_HL  = 2'd1;
	localparam logic [1:0] MS_LH  = 2'd2;
	localparam logic [1:0] MS_SUM = 2'd3;

	typedef struct packed {
		logic        action;
		logic [63:0] item_value;
		logic [11:0] merge_index;
		logic [5:0]  merge_value;
	} hll_in_t;

	typedef struct packed {
		logic [11:0] reg_index;
		logic [5:0]  reg_value;
		logic        changed;
		logic [12:0] zero_regs;
		logic [63:0] recip_sum;
	} hll_out_t;

	typedef struct packed {
		logic       clr_wr;
		logic       take;
		logic       mul_go;
		logic [1:0] mstep;
		logic       k_sel;
		logic       grp_en;
		logic       rho_en;
		logic       rd_en;
		logic       upd_en;
		logic       fin_en;
	} hll_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic merge;
		logic can_load;
	} hll_sts_t;

	function automatic logic [63:0] mix_shift(logic [63:0] x);
		return x ^ (x >> MIX_SHIFT);
	endfunction

	function automatic logic [63:0] term_of(logic [5:0] r);
		if (r > 6'(FRAC_BITS)) begin
			return '0;
		end
		return 64'(1) << (6'(FRAC_BITS) - r);
	endfunction

endpackage

// File: rtl/core/hyperloglog_register_update_top.sv
// Channel   Direction  Handshake               Word
// in        input      in_valid / in_ready     hll_in_t: action, item, merge index and value
// out       output     out_valid / out_ready   hll_out_t: register, change flag, zero count, sum
//
// A word is taken only in idle, so one word is in flight at a time. An insert word first runs
// the murmur hash: each 64-bit multiply runs as three partial products on one shared
// 32 by 32 bit multiplier, then a two-step trailing zero count; a merge word skips both.
// After reset a clearing pass zeroes the 4096-entry register memory with in_ready low. A
// result waits in the output register; the engine stalls in its last step only while that
// register is still full and not being taken.
module hyperloglog_register_update_top import hllru_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  hll_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output hll_out_t out_data
);

	hll_cmd_t cmd;
	hll_sts_t sts;

	hllru_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	hllru_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`include "hyperloglog_register_update_top_assert.svh"

	// Only one word is in flight at a time.
	`HLL_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)
	// A register that grew cannot end at zero.
	`HLL_ASSERT_IMPL(a_changed_nonzero, out_valid && out_data.changed, out_data.reg_value != 6'd0)
	`HLL_ASSERT_IMPL(a_zero_regs_range, out_valid, out_data.zero_regs <= 13'(REG_CNT))

endmodule

// File: rtl/core/hllru_ctrl.sv
module hllru_ctrl import hllru_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  hll_sts_t sts,
	output hll_cmd_t cmd
);

	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_MUL0  = 4'd2;
	localparam logic [3:0] ST_MUL1  = 4'd3;
	localparam logic [3:0] ST_MUL2  = 4'd4;
	localparam logic [3:0] ST_MUL3  = 4'd5;
	localparam logic [3:0] ST_CTZ   = 4'd6;
	localparam logic [3:0] ST_RHO   = 4'd7;
	localparam logic [3:0] ST_READ  = 4'd8;
	localparam logic [3:0] ST_UPD   = 4'd9;
	localparam logic [3:0] ST_FIN   = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_d;
	// Low during the first murmur multiply, high during the second.
	logic       round_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d = sts.merge ? ST_READ : ST_MUL0;
				end
			end
			ST_MUL0: begin
				cmd.mul_go = 1'b1;
				cmd.mstep = MS_LL;
				cmd.k_sel = round_q;
				state_d = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul_go = 1'b1;
				cmd.mstep = MS_HL;
				cmd.k_sel = round_q;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul_go = 1'b1;
				cmd.mstep = MS_LH;
				cmd.k_sel = round_q;
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul_go = 1'b1;
				cmd.mstep = MS_SUM;
				cmd.k_sel = round_q;
				state_d = round_q ? ST_CTZ : ST_MUL0;
			end
			ST_CTZ: begin
				cmd.grp_en = 1'b1;
				state_d = ST_RHO;
			end
			ST_RHO: begin
				cmd.rho_en = 1'b1;
				cmd.rd_en = 1'b1;
				state_d = ST_UPD;
			end
			ST_READ: begin
				cmd.rd_en = 1'b1;
				state_d = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd_en = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin_en = 1'b1;
				if (sts.can_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			round_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL3) begin
				round_q <= ~round_q;
			end
		end
	end

endmodule

// File: rtl/core/hllru_datapath.sv
module hllru_datapath import hllru_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  hll_cmd_t cmd,
	output hll_sts_t sts,
	input  hll_in_t  in_data,
	output logic     out_valid,
	input  logic     out_ready,
	output hll_out_t out_data
);

	logic [5:0]       mem [REG_CNT];
	logic [5:0]       rdata_q;
	logic [IDX_W-1:0] clr_addr_q;

	logic [63:0]      x_q;
	logic [63:0]      acc_q;
	logic [63:0]      prod_q;
	logic [63:0]      k_sel;
	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [63:0]      mul_p;
	logic [63:0]      acc_sum;

	logic [IDX_W-1:0] idx_q;
	logic [5:0]       val_q;
	logic [5:0]       new_reg_q;
	logic             chg_q;
	logic [63:0]      delta_q;
	logic [63:0]      harm_q;
	logic [63:0]      harm_next;
	logic [CNT_W-1:0] zero_q;

	logic [PAD_W-1:0] w_pad;
	logic [GRP_N-1:0] grp_nz;
	logic [2:0]       grp_ctz [GRP_N];
	logic [GRP_N-1:0] grp_nz_q;
	logic [2:0]       grp_ctz_q [GRP_N];
	logic [5:0]       rho_val;

	logic             inc;
	logic             can_load;
	logic             out_valid_q;
	hll_out_t         out_q;

	function automatic logic [2:0] ctz8(logic [7:0] v);
		logic [2:0] c;
		c = '0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				c = 3'(i);
			end
		end
		return c;
	endfunction

	// One 32 by 32 bit multiplier serves all three partial products of x * K.
	assign k_sel = cmd.k_sel ? MIX_MUL_B : MIX_MUL_A;

	always_comb begin
		case (cmd.mstep)
			MS_HL: begin
				mul_a = x_q[63:32];
				mul_b = k_sel[31:0];
			end
			MS_LH: begin
				mul_a = x_q[31:0];
				mul_b = k_sel[63:32];
			end
			default: begin
				mul_a = x_q[31:0];
				mul_b = k_sel[31:0];
			end
		endcase
	end

	assign mul_p = 64'(mul_a) * 64'(mul_b);
	assign acc_sum = {acc_q[63:32] + prod_q[31:0], acc_q[31:0]};

	// Trailing zero count over the hash bits above the index, in byte groups.
	assign w_pad = PAD_W'({1'b1, x_q[63:IDX_W]});

	always_comb begin
		for (int g = 0; g < GRP_N; g++) begin
			grp_nz[g] = |w_pad[g*8 +: 8];
			grp_ctz[g] = ctz8(w_pad[g*8 +: 8]);
		end
	end

	always_comb begin
		rho_val = '0;
		for (int g = GRP_N - 1; g >= 0; g--) begin
			if (grp_nz_q[g]) begin
				rho_val = 6'(g * 8) + 6'(grp_ctz_q[g]) + 6'd1;
			end
		end
	end

	assign inc = (val_q > rdata_q);
	assign can_load = !out_valid_q || out_ready;
	assign harm_next = harm_q - delta_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			x_q <= mix_shift(in_data.item_value);
			idx_q <= IDX_W'(in_data.merge_index);
			val_q <= in_data.merge_value;
		end
		if (cmd.mul_go) begin
			case (cmd.mstep)
				MS_LL: begin
					prod_q <= mul_p;
				end
				MS_HL: begin
					prod_q <= mul_p;
					acc_q <= prod_q;
				end
				MS_LH: begin
					prod_q <= mul_p;
					acc_q <= acc_sum;
				end
				default: begin
					x_q <= mix_shift(acc_sum);
				end
			endcase
		end
		if (cmd.grp_en) begin
			grp_nz_q <= grp_nz;
			grp_ctz_q <= grp_ctz;
			idx_q <= x_q[IDX_W-1:0];
		end
		if (cmd.rho_en) begin
			val_q <= rho_val;
		end
		if (cmd.upd_en) begin
			chg_q <= inc;
			new_reg_q <= inc ? val_q : rdata_q;
			delta_q <= inc ? (term_of(rdata_q) - term_of(val_q)) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_wr) begin
			mem[clr_addr_q] <= '0;
		end else if (cmd.upd_en && inc) begin
			mem[idx_q] <= val_q;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			zero_q <= CNT_W'(REG_CNT);
			harm_q <= HARM_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
			if (cmd.upd_en && inc && (rdata_q == '0)) begin
				zero_q <= zero_q - 1'b1;
			end
			if (cmd.fin_en && can_load) begin
				harm_q <= harm_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_en && can_load) begin
			out_q.reg_index <= 12'(idx_q);
			out_q.reg_value <= new_reg_q;
			out_q.changed <= chg_q;
			out_q.zero_regs <= 13'(zero_q);
			out_q.recip_sum <= harm_next;
		end
	end

	assign sts.clr_last = (clr_addr_q == '1);
	assign sts.merge = in_data.action;
	assign sts.can_load = can_load;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// File: bench/tb_hyperloglog_register_update_top.sv
module tb_hyperloglog_register_update_top;
	timeunit 1ns;
	timeprecision 1ps;

	import hllru_pkg::*;

	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_MERGE = 1'b1;
	localparam int RANDOM_WORDS = 1900;
	localparam int QUIET_LIMIT = 20000;
	localparam int FLUSH_CYCLES = 40;

	// Tracks the expected sketch and the results still owed by the engine.
	class sketch_board;
		logic [5:0] regs [REG_CNT];
		logic [12:0] zeros;
		logic [63:0] hsum;
		hll_out_t awaited [$];
		int errors;
		int inserts;
		int merges;
		int raised;
		int low_zeros;
		int faint;

		function new();
			foreach (regs[i]) regs[i] = '0;
			zeros = 13'(REG_CNT);
			hsum = 64'(REG_CNT) << FRAC_BITS;
			low_zeros = REG_CNT;
		endfunction

		function logic [63:0] fmix(logic [63:0] x);
			x = x ^ (x >> MIX_SHIFT);
			x = x * MIX_MUL_A;
			x = x ^ (x >> MIX_SHIFT);
			x = x * MIX_MUL_B;
			x = x ^ (x >> MIX_SHIFT);
			return x;
		endfunction

		// Terms too small for the fraction bits are dropped.
		function logic [63:0] weight(int r);
			if (r > FRAC_BITS) begin
				return '0;
			end
			return 64'd1 << (FRAC_BITS - r);
		endfunction

		function int rho_of(logic [63:0] h);
			logic [63:0] rest;
			int n;
			rest = (h >> PRECISION) | (64'd1 << (64 - PRECISION));
			n = 0;
			while (n < 64 && !rest[n]) n++;
			return n + 1;
		endfunction

		function void note_word(hll_in_t w);
			logic [63:0] h;
			int slot;
			int grow;
			int old;
			hll_out_t e;
			if (w.action == ACT_INSERT) begin
				h = fmix(w.item_value);
				slot = int'(h[IDX_W-1:0]);
				grow = rho_of(h);
				inserts++;
			end else begin
				slot = int'(w.merge_index) & (REG_CNT - 1);
				grow = int'(w.merge_value);
				merges++;
			end
			old = int'(regs[slot]);
			e.changed = 1'b0;
			if (grow > old) begin
				if (old == 0) begin
					zeros = zeros - 13'd1;
				end
				hsum = hsum - weight(old) + weight(grow);
				regs[slot] = 6'(grow);
				e.changed = 1'b1;
				raised++;
			end
			if (zeros < low_zeros) begin
				low_zeros = int'(zeros);
			end
			if (regs[slot] > FRAC_BITS) begin
				faint++;
			end
			e.reg_index = 12'(slot);
			e.reg_value = regs[slot];
			e.zero_regs = zeros;
			e.recip_sum = hsum;
			awaited.push_back(e);
		endfunction

		function void complain(string msg);
			errors++;
			if (errors <= 10) begin
				$display("[%0t] %s", $realtime, msg);
			end
		endfunction

		function void compare(string field, logic [63:0] exp, logic [63:0] act);
			if (exp !== act) begin
				complain($sformatf("%s mismatch: expected %0h, got %0h", field, exp, act));
			end
		endfunction

		function void check_word(hll_out_t got);
			hll_out_t e;
			if (awaited.size() == 0) begin
				complain($sformatf("result word with nothing pending: %p", got));
				return;
			end
			e = awaited.pop_front();
			compare("reg_index", 64'(e.reg_index), 64'(got.reg_index));
			compare("reg_value", 64'(e.reg_value), 64'(got.reg_value));
			compare("changed", 64'(e.changed), 64'(got.changed));
			compare("zero_regs", 64'(e.zero_regs), 64'(got.zero_regs));
			compare("recip_sum", e.recip_sum, got.recip_sum);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	hll_in_t in_data;
	logic out_valid;
	logic out_ready;
	hll_out_t out_data;

	sketch_board board = new();
	logic [63:0] seen_items [$];
	int idle_pct = 25;
	int quiet = 0;

	hyperloglog_register_update_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Both handshakes are sampled at the edge, before any driver update lands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				board.note_word(in_data);
			end
			if (out_valid && out_ready) begin
				board.check_word(out_data);
			end
		end
	end

	// The clearing pass after reset keeps in_ready low while it zeroes all 2^PRECISION registers.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("Timeout after %0d cycles without a handshake", quiet);
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin : sink_side
		int hold;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 99) < idle_pct / 3) begin
				hold = $urandom_range(1, 18);
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	function automatic hll_in_t insert_word(logic [63:0] item);
		hll_in_t w;
		w.action = ACT_INSERT;
		w.item_value = item;
		w.merge_index = 12'($urandom);
		w.merge_value = 6'($urandom);
		seen_items.push_back(item);
		return w;
	endfunction

	function automatic hll_in_t merge_word(logic [11:0] slot, logic [5:0] val);
		hll_in_t w;
		w.action = ACT_MERGE;
		w.item_value = {$urandom, $urandom};
		w.merge_index = slot;
		w.merge_value = val;
		return w;
	endfunction

	task automatic push_word(hll_in_t w);
		int gap;
		if ($urandom_range(0, 99) < idle_pct) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic run_directed();
		// A zero item hashes to zero, so it lands on register 0 with the largest rho.
		push_word(insert_word(64'h0));
		push_word(insert_word(64'hFFFF_FFFF_FFFF_FFFF));
		push_word(insert_word(64'h0));
		push_word(insert_word(64'h8000_0000_0000_0000));
		push_word(insert_word(64'h5555_5555_5555_5555));
		push_word(insert_word(64'hAAAA_AAAA_AAAA_AAAA));
		push_word(insert_word(64'h1));
		push_word(merge_word(12'd0, 6'd63));
		push_word(merge_word(12'd0, 6'd5));
		push_word(merge_word(12'hFFF, 6'd0));
		push_word(merge_word(12'hFFF, 6'd1));
		push_word(merge_word(12'hFFF, 6'd52));
		push_word(merge_word(12'hFFE, 6'd53));
		push_word(merge_word(12'hFFD, 6'd51));
		push_word(merge_word(12'd1, 6'd52));
		push_word(merge_word(12'd1, 6'd53));
		push_word(merge_word(12'd1, 6'd53));
		push_word(merge_word(12'd2, 6'd63));
		push_word(merge_word(12'hAAA, 6'h2A));
		push_word(merge_word(12'h555, 6'h15));
		push_word(merge_word(12'h555, 6'h14));
	endtask

	task automatic run_random(int count);
		hll_in_t w;
		int pick;
		logic [5:0] val;
		logic [11:0] slot;
		for (int i = 0; i < count; i++) begin
			if (i % 150 == 0) begin
				case ($urandom_range(0, 2))
					0: idle_pct = 0;
					1: idle_pct = 10;
					default: idle_pct = 35;
				endcase
			end
			if (i >= count - 250) begin
				idle_pct = 0;
			end
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				// Replayed items hit a register that cannot grow again.
				if (seen_items.size() != 0 && $urandom_range(0, 6) == 0) begin
					w = insert_word(seen_items[$urandom_range(0, seen_items.size() - 1)]);
				end else begin
					w = insert_word({$urandom, $urandom});
				end
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					slot = 12'($urandom_range(0, 127));
				end else begin
					slot = 12'($urandom);
				end
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					val = 6'($urandom_range(0, 10));
				end else if (pick < 9) begin
					val = 6'($urandom_range(11, 40));
				end else begin
					val = 6'($urandom_range(41, 63));
				end
				w = merge_word(slot, val);
			end
			push_word(w);
		end
	endtask

	initial begin : stimulus
		in_valid <= 1'b0;
		in_data <= '0;
		arst_n <= 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		run_directed();
		run_random(RANDOM_WORDS);
		in_valid <= 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (FLUSH_CYCLES) @(posedge clk);
		$display("Checked %0d inserts and %0d merges; %0d of them raised a register.",
			board.inserts, board.merges, board.raised);
		$display("Zero count fell to %0d; %0d results left a register beyond the sum's reach.",
			board.low_zeros, board.faint);
		if (board.errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches in total", board.errors);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
